@@ rtl/dmst_pkg.sv @@
// Shared types and constants for the destination MAC statistics table.
`default_nettype none
package dmst_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int MAC_W         = 48;
  localparam int LEN_W         = 16;
  localparam int INDEX_W       = 6;
  localparam int PKT_W         = 32;
  localparam int BYTES_W       = 48;
  localparam int FOLD_W        = 8;
  localparam int FOLD_GROUPS   = (TABLE_ENTRIES + FOLD_W - 1) / FOLD_W;

  typedef enum logic {
    KIND_UPDATE = 1'b0,
    KIND_READ   = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_HIT  = 2'd0,
    ST_NEW  = 2'd1,
    ST_FULL = 2'd2,
    ST_READ = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_UPDATE = 2'd1,
    S_FOLD   = 2'd2,
    S_OUT    = 2'd3
  } state_t;

  typedef struct packed {
    kind_t              kind;
    logic [MAC_W-1:0]   dest_mac;
    logic [LEN_W-1:0]   frame_length;
    logic [INDEX_W-1:0] entry_index;
  } in_beat_t;

  typedef struct packed {
    status_t            status;
    logic               entry_valid;
    logic [MAC_W-1:0]   entry_mac;
    logic [PKT_W-1:0]   packet_total;
    logic [BYTES_W-1:0] byte_total;
  } out_beat_t;

  // Contents of one table entry as a cell presents it for the result fold.
  typedef struct packed {
    logic               valid;
    logic [MAC_W-1:0]   mac;
    logic [PKT_W-1:0]   pkts;
    logic [BYTES_W-1:0] bytes;
  } entry_t;

  // Command broadcast from the control to every cell.
  typedef struct packed {
    logic             look;
    logic             upd;
    logic             miss;
    kind_t            kind;
    logic [MAC_W-1:0] mac;
    logic [LEN_W-1:0] len;
  } cell_cmd_t;

endpackage
`default_nettype wire

@@ rtl/dmst_cell.sv @@
// One table entry: stores a MAC with its counters, matches and updates locally.
`default_nettype none
module dmst_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dmst_pkg::cell_cmd_t cmd,
  input  wire logic              rd_sel,
  input  wire logic              prev_used,
  output logic                   used_o,
  output logic                   hit_o,
  output dmst_pkg::entry_t       val_o
);

  logic                          used_r, used_nxt;
  logic                          hit_r, hit_nxt;
  logic                          rd_r, rd_nxt;
  logic                          sel_r, sel_nxt;
  logic [dmst_pkg::MAC_W-1:0]    mac_r, mac_nxt;
  logic [dmst_pkg::PKT_W-1:0]    pkt_r, pkt_nxt;
  logic [dmst_pkg::BYTES_W-1:0]  bytes_r, bytes_nxt;
  logic [dmst_pkg::BYTES_W:0]    bytes_sum;
  logic                          claim;

  assign bytes_sum = {1'b0, bytes_r} + (dmst_pkg::BYTES_W + 1)'(cmd.len);

  // The free entry right after the last used one takes a missed MAC.
  assign claim = cmd.upd && (cmd.kind == dmst_pkg::KIND_UPDATE) && cmd.miss &&
                 !used_r && prev_used;

  always_comb begin
    used_nxt  = used_r;
    hit_nxt   = hit_r;
    rd_nxt    = rd_r;
    sel_nxt   = sel_r;
    mac_nxt   = mac_r;
    pkt_nxt   = pkt_r;
    bytes_nxt = bytes_r;
    if (cmd.look) begin
      hit_nxt = used_r && (mac_r == cmd.mac) && (cmd.kind == dmst_pkg::KIND_UPDATE);
      rd_nxt  = used_r && rd_sel && (cmd.kind == dmst_pkg::KIND_READ);
    end
    if (cmd.upd) begin
      sel_nxt = hit_r || rd_r || claim;
      if (hit_r) begin
        pkt_nxt   = (pkt_r == '1) ? pkt_r : pkt_r + 1'b1;
        bytes_nxt = bytes_sum[dmst_pkg::BYTES_W] ? '1 : bytes_sum[dmst_pkg::BYTES_W-1:0];
      end else if (claim) begin
        used_nxt  = 1'b1;
        mac_nxt   = cmd.mac;
        pkt_nxt   = dmst_pkg::PKT_W'(1);
        bytes_nxt = dmst_pkg::BYTES_W'(cmd.len);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      hit_r  <= 1'b0;
      rd_r   <= 1'b0;
      sel_r  <= 1'b0;
    end else begin
      used_r <= used_nxt;
      hit_r  <= hit_nxt;
      rd_r   <= rd_nxt;
      sel_r  <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mac_r   <= mac_nxt;
    pkt_r   <= pkt_nxt;
    bytes_r <= bytes_nxt;
  end

  assign used_o      = used_r;
  assign hit_o       = hit_r;
  assign val_o.valid = sel_r;
  assign val_o.mac   = sel_r ? mac_r : '0;
  assign val_o.pkts  = sel_r ? pkt_r : '0;
  assign val_o.bytes = sel_r ? bytes_r : '0;

endmodule
`default_nettype wire

@@ rtl/dmst_fold.sv @@
// Registered OR tree that gathers the one selected entry from all cells.
`default_nettype none
module dmst_fold (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire dmst_pkg::entry_t vals [dmst_pkg::TABLE_ENTRIES],
  output dmst_pkg::entry_t      sum
);

  dmst_pkg::entry_t grp_r   [dmst_pkg::FOLD_GROUPS];
  dmst_pkg::entry_t grp_nxt [dmst_pkg::FOLD_GROUPS];

  for (genvar g = 0; g < dmst_pkg::FOLD_GROUPS; g++) begin : g_grp
    always_comb begin
      grp_nxt[g] = '0;
      for (int k = 0; k < dmst_pkg::FOLD_W; k++) begin
        if (g * dmst_pkg::FOLD_W + k < dmst_pkg::TABLE_ENTRIES) begin
          grp_nxt[g] = grp_nxt[g] | vals[g * dmst_pkg::FOLD_W + k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int g = 0; g < dmst_pkg::FOLD_GROUPS; g++) begin
      sum = sum | grp_r[g];
    end
  end

endmodule
`default_nettype wire

@@ rtl/dest_mac_stat_table.sv @@
// Top level of the destination MAC statistics table.
//
// Input channel (in_valid, in_stall, in_data): one beat per packet update or
// entry read. Output channel (out_valid, out_stall, out_data): exactly one
// result beat for every input beat, in the same order.
// The table is a row of cells, one per entry. A packet beat is compared in
// every cell at the accepting edge, the matching cell (or the first free one)
// updates its counters in the next cycle, a two-level OR (first level
// registered) gathers the selected entry, and the result lands in the
// output register. One beat is in work at a time: a new beat is taken only
// after the last one has passed its match, update and fold steps and its
// result has been loaded into the output register.
// The output register lets the next beat be accepted and matched while a
// result still waits; if out_stall holds, the block stops before the output
// register and the held result does not change.
// Reset (rst_n low at a clock edge) empties the whole table and drops any
// beat in work; entries fill again in first-seen order.
`default_nettype none
module dest_mac_stat_table (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire dmst_pkg::in_beat_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output dmst_pkg::out_beat_t     out_data
);

  localparam int N = dmst_pkg::TABLE_ENTRIES;

  dmst_pkg::state_t    state_r, state_nxt;
  dmst_pkg::in_beat_t  key_r;
  dmst_pkg::status_t   status_r, status_nxt;
  dmst_pkg::out_beat_t out_r;
  logic                out_valid_r, out_valid_nxt;
  logic                look, upd, fold_en, out_load;

  dmst_pkg::cell_cmd_t cmd;
  logic [N-1:0]        used_vec;
  logic [N-1:0]        hit_vec;
  logic [N-1:0]        rd_dec;
  dmst_pkg::entry_t    cell_vals [N];
  dmst_pkg::entry_t    fold_sum;
  logic                any_hit;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dmst_pkg::S_IDLE:   if (in_valid) state_nxt = dmst_pkg::S_UPDATE;
      dmst_pkg::S_UPDATE: state_nxt = dmst_pkg::S_FOLD;
      dmst_pkg::S_FOLD:   state_nxt = dmst_pkg::S_OUT;
      dmst_pkg::S_OUT:    if (!out_valid_r || !out_stall) state_nxt = dmst_pkg::S_IDLE;
      default:            state_nxt = dmst_pkg::S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_stall = 1'b1;
    look     = 1'b0;
    upd      = 1'b0;
    fold_en  = 1'b0;
    out_load = 1'b0;
    case (state_r)
      dmst_pkg::S_IDLE: begin
        in_stall = 1'b0;
        look     = in_valid;
      end
      dmst_pkg::S_UPDATE: upd = 1'b1;
      dmst_pkg::S_FOLD:   fold_en = 1'b1;
      dmst_pkg::S_OUT:    out_load = !out_valid_r || !out_stall;
      default:            in_stall = 1'b1;
    endcase
  end

  assign any_hit = |hit_vec;

  // Matching uses the beat on the port; the update uses the held copy.
  assign cmd.look = look;
  assign cmd.upd  = upd;
  assign cmd.miss = !any_hit;
  assign cmd.kind = look ? in_data.kind : key_r.kind;
  assign cmd.mac  = look ? in_data.dest_mac : key_r.dest_mac;
  assign cmd.len  = key_r.frame_length;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic prev_used;

    assign rd_dec[i] = (32'(in_data.entry_index) == 32'(i));

    if (i == 0) begin : g_first
      assign prev_used = 1'b1;
    end else begin : g_rest
      assign prev_used = used_vec[i-1];
    end

    dmst_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .rd_sel    (rd_dec[i]),
      .prev_used (prev_used),
      .used_o    (used_vec[i]),
      .hit_o     (hit_vec[i]),
      .val_o     (cell_vals[i])
    );
  end

  dmst_fold u_fold (
    .clk  (clk),
    .en   (fold_en),
    .vals (cell_vals),
    .sum  (fold_sum)
  );

  always_comb begin
    status_nxt = status_r;
    if (upd) begin
      if (key_r.kind == dmst_pkg::KIND_READ) begin
        status_nxt = dmst_pkg::ST_READ;
      end else if (any_hit) begin
        status_nxt = dmst_pkg::ST_HIT;
      end else if (!used_vec[N-1]) begin
        status_nxt = dmst_pkg::ST_NEW;
      end else begin
        status_nxt = dmst_pkg::ST_FULL;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dmst_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    if (look) begin
      key_r <= in_data;
    end
    if (out_load) begin
      out_r.status       <= status_r;
      out_r.entry_valid  <= fold_sum.valid;
      out_r.entry_mac    <= fold_sum.mac;
      out_r.packet_total <= fold_sum.pkts;
      out_r.byte_total   <= fold_sum.bytes;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

@@ rtl/dmst_checker.sv @@
// Port-level assertions for the destination MAC statistics table.
`default_nettype none
module dmst_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire dmst_pkg::out_beat_t out_data
);

  // A stalled result beat stays and does not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // Only one item is in work, so the input stalls right after a beat.
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in work");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == dmst_pkg::ST_FULL) |->
      !out_data.entry_valid && (out_data.entry_mac == '0) &&
      (out_data.packet_total == '0) && (out_data.byte_total == '0))
    else $error("table-full result carries entry data");

  a_update_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_data.status == dmst_pkg::ST_HIT) ||
                  (out_data.status == dmst_pkg::ST_NEW)) |->
      out_data.entry_valid && (out_data.packet_total != '0))
    else $error("updated entry reported empty");

  a_new_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == dmst_pkg::ST_NEW) |->
      (out_data.packet_total == dmst_pkg::PKT_W'(1)))
    else $error("new entry count is not one");

endmodule

bind dest_mac_stat_table dmst_checker u_dmst_checker (.*);
`default_nettype wire

@@ bench/dest_mac_stat_table_tb.sv @@
// Self-checking testbench for the destination MAC statistics table.
`timescale 1ns / 100ps
module dest_mac_stat_table_tb;

  localparam int QUIET_LIMIT = 1000;
  localparam int RANDOM_BEATS = 1030;
  localparam int ERR_PRINT_MAX = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  dmst_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  dmst_pkg::out_beat_t out_data;

  // Shadow copy of the table, updated as beats are accepted.
  bit tbl_used [dmst_pkg::TABLE_ENTRIES];
  bit [dmst_pkg::MAC_W-1:0] tbl_mac [dmst_pkg::TABLE_ENTRIES];
  bit [dmst_pkg::PKT_W-1:0] tbl_pkts [dmst_pkg::TABLE_ENTRIES];
  bit [dmst_pkg::BYTES_W-1:0] tbl_bytes [dmst_pkg::TABLE_ENTRIES];

  dmst_pkg::in_beat_t pend_q [$];
  dmst_pkg::out_beat_t tally_q [$];
  logic [dmst_pkg::MAC_W-1:0] mac_seen [$];

  bit in_took = 1'b0;
  int quiet = 0;
  int n_queued = 0;
  int n_taken = 0;
  int n_err = 0;
  int n_hit = 0;
  int n_new = 0;
  int n_full = 0;
  int n_read = 0;
  int n_read_used = 0;

  dest_mac_stat_table u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // Applies one beat to the shadow table and returns the result it must produce.
  function automatic dmst_pkg::out_beat_t tally_beat(input dmst_pkg::in_beat_t b);
    dmst_pkg::out_beat_t r;
    int free_at;
    logic [dmst_pkg::BYTES_W:0] sum;
    r = '0;
    free_at = -1;
    if (b.kind == dmst_pkg::KIND_READ) begin
      r.status = dmst_pkg::ST_READ;
      if (int'(b.entry_index) < dmst_pkg::TABLE_ENTRIES && tbl_used[b.entry_index]) begin
        r.entry_valid = 1'b1;
        r.entry_mac = tbl_mac[b.entry_index];
        r.packet_total = tbl_pkts[b.entry_index];
        r.byte_total = tbl_bytes[b.entry_index];
      end
      return r;
    end
    for (int i = 0; i < dmst_pkg::TABLE_ENTRIES; i++) begin
      if (tbl_used[i] && tbl_mac[i] == b.dest_mac) begin
        if (tbl_pkts[i] != '1) tbl_pkts[i] = tbl_pkts[i] + 1'b1;
        sum = {1'b0, tbl_bytes[i]} + (dmst_pkg::BYTES_W + 1)'(b.frame_length);
        tbl_bytes[i] = sum[dmst_pkg::BYTES_W] ? '1 : sum[dmst_pkg::BYTES_W-1:0];
        r.status = dmst_pkg::ST_HIT;
        r.entry_valid = 1'b1;
        r.entry_mac = tbl_mac[i];
        r.packet_total = tbl_pkts[i];
        r.byte_total = tbl_bytes[i];
        return r;
      end
      if (!tbl_used[i] && free_at < 0) free_at = i;
    end
    if (free_at >= 0) begin
      tbl_used[free_at] = 1'b1;
      tbl_mac[free_at] = b.dest_mac;
      tbl_pkts[free_at] = dmst_pkg::PKT_W'(1);
      tbl_bytes[free_at] = dmst_pkg::BYTES_W'(b.frame_length);
      r.status = dmst_pkg::ST_NEW;
      r.entry_valid = 1'b1;
      r.entry_mac = b.dest_mac;
      r.packet_total = dmst_pkg::PKT_W'(1);
      r.byte_total = dmst_pkg::BYTES_W'(b.frame_length);
    end else begin
      r.status = dmst_pkg::ST_FULL;
    end
    return r;
  endfunction

  function automatic logic [dmst_pkg::MAC_W-1:0] rand_mac();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[dmst_pkg::MAC_W-1:0];
  endfunction

  function automatic logic [dmst_pkg::LEN_W-1:0] rand_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return '0;
    if (roll < 10) return '1;
    if (roll < 40) return dmst_pkg::LEN_W'($urandom_range(0, 65535));
    return dmst_pkg::LEN_W'($urandom_range(64, 1518));
  endfunction

  // A MAC that is already in the table, as far as the stimulus order tells.
  function automatic logic [dmst_pkg::MAC_W-1:0] known_mac();
    int top;
    top = (mac_seen.size() < dmst_pkg::TABLE_ENTRIES) ? mac_seen.size() :
          dmst_pkg::TABLE_ENTRIES;
    return mac_seen[$urandom_range(0, top - 1)];
  endfunction

  task automatic push_update(input logic [dmst_pkg::MAC_W-1:0] mac,
                             input logic [dmst_pkg::LEN_W-1:0] len);
    dmst_pkg::in_beat_t b;
    bit known;
    known = 1'b0;
    b.kind = dmst_pkg::KIND_UPDATE;
    b.dest_mac = mac;
    b.frame_length = len;
    b.entry_index = dmst_pkg::INDEX_W'($urandom_range(0, 63));
    pend_q.insert(pend_q.size(), b);
    foreach (mac_seen[i]) if (mac_seen[i] == mac) known = 1'b1;
    if (!known) mac_seen.insert(mac_seen.size(), mac);
  endtask

  task automatic push_read(input int idx);
    dmst_pkg::in_beat_t b;
    b.kind = dmst_pkg::KIND_READ;
    b.dest_mac = rand_mac();
    b.frame_length = dmst_pkg::LEN_W'($urandom_range(0, 65535));
    b.entry_index = dmst_pkg::INDEX_W'(idx);
    pend_q.insert(pend_q.size(), b);
  endtask

  task automatic report_field(input string fld, input logic [63:0] want,
                              input logic [63:0] got);
    n_err++;
    if (n_err <= ERR_PRINT_MAX)
      $display("%0t: %s mismatch, expected %h, got %h", $time, fld, want, got);
  endtask

  task automatic check_result(input dmst_pkg::out_beat_t want,
                              input dmst_pkg::out_beat_t got);
    if (got.status !== want.status)
      report_field("status", 64'(want.status), 64'(got.status));
    if (got.entry_valid !== want.entry_valid)
      report_field("entry_valid", 64'(want.entry_valid), 64'(got.entry_valid));
    if (got.entry_mac !== want.entry_mac)
      report_field("entry_mac", 64'(want.entry_mac), 64'(got.entry_mac));
    if (got.packet_total !== want.packet_total)
      report_field("packet_total", 64'(want.packet_total), 64'(got.packet_total));
    if (got.byte_total !== want.byte_total)
      report_field("byte_total", 64'(want.byte_total), 64'(got.byte_total));
    case (want.status)
      dmst_pkg::ST_HIT:  n_hit++;
      dmst_pkg::ST_NEW:  n_new++;
      dmst_pkg::ST_FULL: n_full++;
      dmst_pkg::ST_READ: begin
        n_read++;
        if (want.entry_valid) n_read_used++;
      end
      default: ;
    endcase
  endtask

  // Driver: changes inputs on the falling edge. Between beat 450 and 650 neither
  // side idles, so the block also runs at its full rate for a while.
  always @(negedge clk) begin : driver
    bit calm;
    bit idle_in;
    calm = (n_taken >= 450 && n_taken < 650);
    idle_in = ($urandom_range(0, 99) < 34) && !calm;
    out_stall <= ($urandom_range(0, 99) < 34) && !calm;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pend_q.size() != 0 && !idle_in) begin
        in_valid <= 1'b1;
        in_data <= pend_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: samples both channels on the rising edge.
  always @(posedge clk) begin : monitor
    dmst_pkg::out_beat_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
      quiet <= 0;
    end else begin
      in_took <= in_valid && !in_stall;
      // Results are checked before this edge's input beat is predicted, since a
      // result can never belong to a beat accepted at the same edge.
      if (out_valid && !out_stall) begin
        if (tally_q.size() == 0) begin
          n_err++;
          if (n_err <= ERR_PRINT_MAX)
            $display("%0t: result beat with nothing outstanding, expected none, got %h",
                     $time, out_data);
        end else begin
          want = tally_q.pop_front();
          check_result(want, out_data);
        end
      end
      if (in_valid && !in_stall) begin
        tally_q.insert(tally_q.size(), tally_beat(in_data));
        n_taken++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles", QUIET_LIMIT);
        $display("FAIL");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    int roll;
    int fresh_pct;

    // Directed part: empty-table reads, the extreme MACs and lengths, hits on
    // them, and single-bit neighbors that must not match. The counters cannot
    // reach saturation in a run of this length.
    push_read(0);
    push_read(63);
    push_update('0, '0);
    push_update('1, '1);
    push_update('0, '1);
    push_update('1, '0);
    push_update(48'hAAAA_AAAA_AAAA, 16'h5555);
    push_update(48'h5555_5555_5555, 16'hAAAA);
    push_update(48'h0000_0000_0001, 16'd64);
    push_update(48'h8000_0000_0000, 16'd1518);
    push_update(48'hAAAA_AAAA_AAAA, 16'hFFFF);
    push_read(0);
    push_read(1);
    push_read(5);
    push_read(6);
    push_read(63);

    // Random part. Fresh MACs are rare at first so the table fills slowly, then
    // common so that many beats find it full.
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      roll = $urandom_range(0, 99);
      fresh_pct = (i < 500) ? 8 : 30;
      if (roll < 25) begin
        push_read($urandom_range(0, 63));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < fresh_pct)
          push_update(rand_mac(), rand_len());
        else if (roll < fresh_pct + 10)
          push_update(known_mac() ^ (48'h1 << $urandom_range(0, 47)), rand_len());
        else
          push_update(known_mac(), rand_len());
      end
    end
    n_queued = pend_q.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (n_taken < n_queued || tally_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Checked %0d beats: %0d hits, %0d new entries, %0d dropped on a full table,",
             n_taken, n_hit, n_new, n_full);
    $display("and %0d reads, %0d of them of a used entry.", n_read, n_read_used);
    if (n_err == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
